@@ design/adsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsc_pkg
// Shared types and constants for the airbrake deployment slew controller.
// ----------------------------------------------------------------------------
package adsc_pkg;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_OPEN   = 2'd1,
    PH_CLOSED = 2'd2
  } phase_t;

  // configuration register indexes
  localparam logic [1:0] CFG_OPEN_ALT  = 2'd0;
  localparam logic [1:0] CFG_CLOSE_ALT = 2'd1;
  localparam logic [1:0] CFG_OPEN_RATE = 2'd2;
  localparam logic [1:0] CFG_CLOSE_RATE = 2'd3;

  localparam int ALT_W   = 25;
  localparam int LEVEL_W = 16;
  localparam int TICK_W  = 16;
  localparam int RATE_W  = 24;
  localparam int PROD_W  = RATE_W + TICK_W;

  localparam logic [LEVEL_W-1:0] FULL_OPEN  = 16'hFFFF;
  localparam logic [RATE_W-1:0]  RATE_RESET = 24'h010000;

  // per-word data carried alongside the divider
  typedef struct packed {
    logic [LEVEL_W-1:0] cur;
    logic               tgt_open;
    phase_t             phase;
  } side_t;

endpackage

@@ design/adsc_div_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsc_div_stage
// Division by a constant through reciprocal multiplication, saturating at
// full travel.
// ----------------------------------------------------------------------------
module adsc_div_stage import adsc_pkg::*; #(
  parameter int DIVISOR = 1000
) (
  input  logic [PROD_W-1:0]  dividend,
  output logic [LEVEL_W-1:0] quotient
);

  // below the saturation limit the dividend fits NUM_W bits, and a multiplier
  // of NUM_W + 1 bits with a shift of NUM_W + DIV_LOG gives the exact quotient
  localparam int DIV_LOG = $clog2(DIVISOR);
  localparam int NUM_W   = LEVEL_W + DIV_LOG;
  localparam int SHIFT   = NUM_W + DIV_LOG;
  localparam int MAG_W   = NUM_W + 1;
  localparam logic [PROD_W-1:0] SAT_LIMIT  = PROD_W'(DIVISOR) << LEVEL_W;
  localparam logic [63:0]       MAGIC_WIDE =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MAG_W-1:0]  MAGIC      = MAGIC_WIDE[MAG_W-1:0];

  logic [NUM_W+MAG_W-1:0] scaled;

  assign scaled   = {{MAG_W{1'b0}}, dividend[NUM_W-1:0]} * {{NUM_W{1'b0}}, MAGIC};
  assign quotient = (dividend >= SAT_LIMIT) ? FULL_OPEN : scaled[SHIFT +: LEVEL_W];

endmodule

@@ design/airbrake_deploy_slew_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airbrake_deploy_slew_controller_core
// Airbrake phase sequencer and slew-rate limited deployment command.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output side is not stalled and
// returns one result per word, in order, through the input register, the
// rate x ticks product register, and the output register, in front
// of which the step is divided by TICK_RATE_HZ through a reciprocal multiply
// and applied toward the target. A stalled output backs words up into the
// product and input registers, then drops in_ready. The phase sequencer is
// updated as a word leaves the input register, so consecutive words see each
// other's phase changes. Configuration writes are accepted every cycle and
// must only be made while no words are in flight.
module airbrake_deploy_slew_controller_core import adsc_pkg::*; #(
  parameter int PERIOD_TICKS = 50,
  parameter int TICK_RATE_HZ = 1000
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [ALT_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ALT_W-1:0]   altitude,
  input  logic [LEVEL_W-1:0]        current_level,
  input  logic [TICK_W-1:0]         elapsed_ticks,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [LEVEL_W-1:0]        new_command,
  output logic [1:0]                brake_phase
);

  localparam logic [TICK_W-1:0] TICK_CAP = TICK_W'(PERIOD_TICKS);

  // configuration
  logic signed [ALT_W-1:0] open_alt;
  logic signed [ALT_W-1:0] close_alt;
  logic [RATE_W-1:0]       open_rate;
  logic [RATE_W-1:0]       close_rate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_alt   <= '0;
      close_alt  <= '0;
      open_rate  <= RATE_RESET;
      close_rate <= RATE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OPEN_ALT:   open_alt   <= cfg_data;
        CFG_CLOSE_ALT:  close_alt  <= cfg_data;
        CFG_OPEN_RATE:  open_rate  <= cfg_data[RATE_W-1:0];
        CFG_CLOSE_RATE: close_rate <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic vld_in;
  logic vld_prod;
  logic rdy_prod;
  logic out_valid_q;
  logic rdy_out;

  assign out_valid = out_valid_q;
  assign rdy_out   = !out_valid_q || out_ready;
  assign rdy_prod  = !vld_prod || rdy_out;
  assign in_ready  = !vld_in || rdy_prod;

  // input register
  logic signed [ALT_W-1:0] alt_q;
  logic [LEVEL_W-1:0]      cur_q;
  logic [TICK_W-1:0]       ticks_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_in <= 1'b0;
    end else if (in_ready) begin
      vld_in <= in_valid;
    end
    if (in_ready) begin
      alt_q   <= altitude;
      cur_q   <= current_level;
      ticks_q <= elapsed_ticks;
    end
  end

  // phase sequencer and rate select
  phase_t              phase;
  phase_t              phase_next;
  logic                tgt_open;
  logic [LEVEL_W-1:0]  tgt_lvl;
  logic [RATE_W-1:0]   rate;
  logic [TICK_W-1:0]   ticks_cap;
  logic [PROD_W-1:0]   product;

  always_comb begin
    phase_next = phase;
    tgt_open   = 1'b0;
    case (phase)
      PH_WAIT: begin
        if (alt_q >= open_alt) begin
          phase_next = PH_OPEN;
          tgt_open   = 1'b1;
        end
      end
      PH_OPEN: begin
        tgt_open = 1'b1;
        if (alt_q >= close_alt) begin
          phase_next = PH_CLOSED;
          tgt_open   = 1'b0;
        end
      end
      default: tgt_open = 1'b0;
    endcase
    tgt_lvl   = tgt_open ? FULL_OPEN : '0;
    rate      = (tgt_lvl > cur_q) ? open_rate : close_rate;
    ticks_cap = (ticks_q > TICK_CAP) ? TICK_CAP : ticks_q;
    product   = {{TICK_W{1'b0}}, rate} * {{RATE_W{1'b0}}, ticks_cap};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
    end else if (vld_in && rdy_prod) begin
      phase <= phase_next;
    end
  end

  // product register
  logic [PROD_W-1:0] prod_q;
  side_t             side_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_prod <= 1'b0;
    end else if (rdy_prod) begin
      vld_prod <= vld_in;
    end
    if (rdy_prod) begin
      prod_q <= product;
      side_q <= '{cur: cur_q, tgt_open: tgt_open, phase: phase_next};
    end
  end

  // step = product / TICK_RATE_HZ, saturated at full travel
  logic [LEVEL_W-1:0] step;

  adsc_div_stage #(
    .DIVISOR (TICK_RATE_HZ)
  ) u_div (
    .dividend (prod_q),
    .quotient (step)
  );

  // move toward target
  logic [LEVEL_W-1:0] nxt;

  always_comb begin
    logic [LEVEL_W-1:0] tgt;
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W:0]   sum;
    cur  = side_q.cur;
    tgt  = side_q.tgt_open ? FULL_OPEN : '0;
    sum  = {1'b0, cur} + {1'b0, step};
    nxt  = cur;
    if (cur < tgt) begin
      nxt = (sum > {1'b0, tgt}) ? tgt : sum[LEVEL_W-1:0];
    end else if (cur > tgt) begin
      nxt = ((cur - tgt) <= step) ? tgt : (cur - step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (rdy_out) begin
      out_valid_q <= vld_prod;
    end
    if (rdy_out) begin
      new_command <= nxt;
      brake_phase <= side_q.phase;
    end
  end

`ifndef NO_ASSERTIONS
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CLOSED) |=> (phase == PH_CLOSED))
    else $error("phase left closed");

  a_phase_moves_with_word: assert property (@(posedge clk) disable iff (rst)
    !(vld_in && rdy_prod) |=> $stable(phase))
    else $error("phase changed with no word leaving input stage");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid_q && !out_ready) |=>
      (out_valid_q && $stable(new_command) && $stable(brake_phase)))
    else $error("stalled result changed");

  a_no_backstep: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_OPEN) |=> (phase != PH_WAIT))
    else $error("phase returned to waiting");
`endif

endmodule
